@@ src/skvt_pkg.sv @@
// Shared constants and types for the sorted key/value table.
package skvt_pkg;

   localparam int CAPACITY = 16;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int KEY_W    = 32;
   localparam int VAL_W    = 32;
   localparam int CMD_W    = 2;
   localparam int STAT_W   = 3;
   localparam int COUNT_W  = 5;

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_LOOKUP = 2'd2,
      CMD_CLEAR  = 2'd3
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_INSERTED  = 3'd0,
      STAT_UPDATED   = 3'd1,
      STAT_REMOVED   = 3'd2,
      STAT_FOUND     = 3'd3,
      STAT_NOT_FOUND = 3'd4,
      STAT_FULL      = 3'd5,
      STAT_CLEARED   = 3'd6
   } status_type;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [VAL_W-1:0] value;
   } entry_type;

   typedef struct packed {
      logic                 wr_en;
      logic [IDX_W-1:0]     wr_addr;
      entry_type            wr_data;
      logic [IDX_W-1:0]     rd_addr;
   } ram_ctrl_type;

endpackage

@@ src/skvt_ram.sv @@
// Entry store: one write port, one read port, registered read data.
module skvt_ram (
   input  logic                  clock,
   input  skvt_pkg::ram_ctrl_type ctrl,
   output skvt_pkg::entry_type   rd_data
);

   skvt_pkg::entry_type mem [skvt_pkg::CAPACITY];
   skvt_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         mem[ctrl.wr_addr] <= ctrl.wr_data;
      end
      rd_data_ff <= mem[ctrl.rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/sorted_key_value_table.sv @@
// Sorted key/value table: top level with command sequencer and entry store.
// Steps: clear answers straight from idle; other commands scan the store from slot 0 to the
// deciding slot; insert then moves later entries up one slot at a time and places the new
// entry, remove moves later entries down one slot at a time. The next command is taken in
// the cycle the result is out, and the receiver cannot stall the result.
// Reset clears the entry count and control; store contents stay as they are.
module sorted_key_value_table (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [skvt_pkg::CMD_W-1:0]         req_cmd,
   input  logic signed [skvt_pkg::KEY_W-1:0]  req_key_in,
   input  logic signed [skvt_pkg::VAL_W-1:0]  req_value_in,
   output logic                               rsp_strobe,
   output logic [skvt_pkg::STAT_W-1:0]        rsp_status,
   output logic signed [skvt_pkg::VAL_W-1:0]  rsp_value_out,
   output logic [skvt_pkg::COUNT_W-1:0]       rsp_entry_count
);

   localparam int CNT_W = skvt_pkg::CNT_W;
   localparam int IDX_W = skvt_pkg::IDX_W;

   typedef enum logic [4:0] {
      ST_IDLE     = 5'b00001,
      ST_SEARCH   = 5'b00010,
      ST_SHIFT_UP = 5'b00100,
      ST_PLACE    = 5'b01000,
      ST_SHIFT_DN = 5'b10000
   } fsm_type;

   fsm_type                        state_ff, state_in;
   skvt_pkg::cmd_type              cmd_ff, cmd_in;
   logic [skvt_pkg::KEY_W-1:0]     key_ff, key_in;
   logic [skvt_pkg::VAL_W-1:0]     val_ff, val_in;
   logic [CNT_W-1:0]               used_ff, used_in;
   logic [CNT_W-1:0]               idx_ff, idx_in;
   logic [CNT_W-1:0]               pos_ff, pos_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   skvt_pkg::status_type           rsp_status_ff, rsp_status_in;
   logic [skvt_pkg::VAL_W-1:0]     rsp_value_ff, rsp_value_in;
   logic [skvt_pkg::COUNT_W-1:0]   rsp_count_ff, rsp_count_in;

   skvt_pkg::ram_ctrl_type         ram_ctrl;
   skvt_pkg::entry_type            rd_data;

   // decision inputs from the scan
   logic                           dec_go;
   logic [CNT_W-1:0]               dec_pos;
   logic                           dec_match;
   logic [CNT_W-1:0]               idx_next;
   logic [CNT_W-1:0]               idx_prev;
   logic [CNT_W-1:0]               rd_addr;
   logic                           key_ge;

   skvt_ram u_ram (
      .clock   (clock),
      .ctrl    (ram_ctrl),
      .rd_data (rd_data)
   );

   assign idx_next = CNT_W'(idx_ff + 1'b1);
   assign idx_prev = CNT_W'(idx_ff - 1'b1);
   assign key_ge   = $signed(rd_data.key) >= $signed(key_ff);

   // end of scan: first slot not below the key, or end of table
   always_comb begin
      dec_go    = 1'b0;
      dec_pos   = idx_ff;
      dec_match = 1'b0;
      if (state_ff == ST_SEARCH) begin
         if (used_ff == '0) begin
            dec_go  = 1'b1;
            dec_pos = '0;
         end else if (key_ge) begin
            dec_go    = 1'b1;
            dec_pos   = idx_ff;
            dec_match = (rd_data.key == key_ff);
         end else if (idx_next == used_ff) begin
            dec_go  = 1'b1;
            dec_pos = used_ff;
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      key_in        = key_ff;
      val_in        = val_ff;
      used_in       = used_ff;
      idx_in        = idx_ff;
      pos_in        = pos_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = '0;
      rd_addr       = '0;
      ram_ctrl.wr_en         = 1'b0;
      ram_ctrl.wr_addr       = '0;
      ram_ctrl.wr_data.key   = key_ff;
      ram_ctrl.wr_data.value = val_ff;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd_in = skvt_pkg::cmd_type'(req_cmd);
               key_in = req_key_in;
               val_in = req_value_in;
               if (skvt_pkg::cmd_type'(req_cmd) == skvt_pkg::CMD_CLEAR) begin
                  used_in       = '0;
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = skvt_pkg::STAT_CLEARED;
               end else begin
                  idx_in   = '0;
                  rd_addr  = '0;
                  state_in = ST_SEARCH;
               end
            end
         end

         ST_SEARCH: begin
            if (dec_go) begin
               pos_in   = dec_pos;
               state_in = ST_IDLE;
               case (cmd_ff)
                  skvt_pkg::CMD_LOOKUP: begin
                     rsp_valid_in = 1'b1;
                     if (dec_match) begin
                        rsp_status_in = skvt_pkg::STAT_FOUND;
                        rsp_value_in  = rd_data.value;
                     end else begin
                        rsp_status_in = skvt_pkg::STAT_NOT_FOUND;
                     end
                  end
                  skvt_pkg::CMD_INSERT: begin
                     if (dec_match) begin
                        ram_ctrl.wr_en   = 1'b1;
                        ram_ctrl.wr_addr = dec_pos[IDX_W-1:0];
                        rsp_valid_in     = 1'b1;
                        rsp_status_in    = skvt_pkg::STAT_UPDATED;
                     end else if (used_ff == CNT_W'(skvt_pkg::CAPACITY)) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = skvt_pkg::STAT_FULL;
                     end else if (dec_pos == used_ff) begin
                        // append at the end
                        ram_ctrl.wr_en   = 1'b1;
                        ram_ctrl.wr_addr = dec_pos[IDX_W-1:0];
                        used_in          = CNT_W'(used_ff + 1'b1);
                        rsp_valid_in     = 1'b1;
                        rsp_status_in    = skvt_pkg::STAT_INSERTED;
                     end else begin
                        // open a gap: move entries up from the top
                        idx_in   = used_ff;
                        rd_addr  = CNT_W'(used_ff - 1'b1);
                        state_in = ST_SHIFT_UP;
                     end
                  end
                  skvt_pkg::CMD_REMOVE: begin
                     if (!dec_match) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = skvt_pkg::STAT_NOT_FOUND;
                     end else if (CNT_W'(dec_pos + 1'b1) == used_ff) begin
                        used_in       = CNT_W'(used_ff - 1'b1);
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = skvt_pkg::STAT_REMOVED;
                     end else begin
                        // close the gap: move entries down
                        idx_in   = dec_pos;
                        rd_addr  = CNT_W'(dec_pos + 1'b1);
                        state_in = ST_SHIFT_DN;
                     end
                  end
                  default: begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = skvt_pkg::STAT_CLEARED;
                     used_in       = '0;
                  end
               endcase
            end else begin
               // advance the scan
               idx_in  = idx_next;
               rd_addr = idx_next;
            end
         end

         ST_SHIFT_UP: begin
            ram_ctrl.wr_en   = 1'b1;
            ram_ctrl.wr_addr = idx_ff[IDX_W-1:0];
            ram_ctrl.wr_data = rd_data;
            idx_in           = idx_prev;
            if (idx_prev == pos_ff) begin
               state_in = ST_PLACE;
            end else begin
               rd_addr = CNT_W'(idx_prev - 1'b1);
            end
         end

         ST_PLACE: begin
            ram_ctrl.wr_en   = 1'b1;
            ram_ctrl.wr_addr = pos_ff[IDX_W-1:0];
            used_in          = CNT_W'(used_ff + 1'b1);
            rsp_valid_in     = 1'b1;
            rsp_status_in    = skvt_pkg::STAT_INSERTED;
            state_in         = ST_IDLE;
         end

         ST_SHIFT_DN: begin
            ram_ctrl.wr_en   = 1'b1;
            ram_ctrl.wr_addr = idx_ff[IDX_W-1:0];
            ram_ctrl.wr_data = rd_data;
            idx_in           = idx_next;
            if (CNT_W'(idx_next + 1'b1) == used_ff) begin
               used_in       = CNT_W'(used_ff - 1'b1);
               rsp_valid_in  = 1'b1;
               rsp_status_in = skvt_pkg::STAT_REMOVED;
               state_in      = ST_IDLE;
            end else begin
               rd_addr = CNT_W'(idx_next + 1'b1);
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      ram_ctrl.rd_addr = rd_addr[IDX_W-1:0];
      rsp_count_in     = skvt_pkg::COUNT_W'(used_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      key_ff        <= key_in;
      val_ff        <= val_in;
      idx_ff        <= idx_in;
      pos_ff        <= pos_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_strobe      = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_value_out   = rsp_value_ff;
   assign rsp_entry_count = rsp_count_ff;

endmodule

@@ verif/sorted_key_value_table_checker.sv @@
`timescale 1ns / 100ps
// Checker for the sorted key/value table: predicts every response beat and compares it.
module sorted_key_value_table_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic                                busy,
   input  logic [skvt_pkg::CMD_W-1:0]          req_cmd,
   input  logic signed [skvt_pkg::KEY_W-1:0]   req_key_in,
   input  logic signed [skvt_pkg::VAL_W-1:0]   req_value_in,
   input  logic                                rsp_strobe,
   input  logic [skvt_pkg::STAT_W-1:0]         rsp_status,
   input  logic signed [skvt_pkg::VAL_W-1:0]   rsp_value_out,
   input  logic [skvt_pkg::COUNT_W-1:0]        rsp_entry_count,
   output int                                  mismatch_count,
   output int                                  pending_count
);

   typedef struct {
      skvt_pkg::status_type              status;
      logic signed [skvt_pkg::VAL_W-1:0] value;
      logic [skvt_pkg::COUNT_W-1:0]      count;
   } answer_type;

   logic signed [skvt_pkg::KEY_W-1:0] table_keys   [skvt_pkg::CAPACITY];
   logic signed [skvt_pkg::VAL_W-1:0] table_values [skvt_pkg::CAPACITY];
   int                                entries_held = 0;
   answer_type                        expected_answers [$];
   int                                errors = 0;
   int                                waiting = 0;

   assign mismatch_count = errors;
   assign pending_count  = waiting;

   // Apply one command to the shadow table and work out its response.
   task automatic predict_answer(input skvt_pkg::cmd_type cmd,
                                 input logic signed [skvt_pkg::KEY_W-1:0] key,
                                 input logic signed [skvt_pkg::VAL_W-1:0] value,
                                 output answer_type answer);
      int slot;
      int i;
      bit hit;
      answer.value = '0;
      answer.status = skvt_pkg::STAT_CLEARED;
      if (cmd == skvt_pkg::CMD_CLEAR) begin
         entries_held = 0;
      end else begin
         slot = 0;
         while (slot < entries_held && table_keys[slot] < key)
            slot++;
         hit = (slot < entries_held) && (table_keys[slot] == key);
         case (cmd)
            skvt_pkg::CMD_INSERT: begin
               if (hit) begin
                  table_values[slot] = value;
                  answer.status = skvt_pkg::STAT_UPDATED;
               end else if (entries_held >= skvt_pkg::CAPACITY) begin
                  answer.status = skvt_pkg::STAT_FULL;
               end else begin
                  for (i = entries_held; i > slot; i--) begin
                     table_keys[i]   = table_keys[i-1];
                     table_values[i] = table_values[i-1];
                  end
                  table_keys[slot]   = key;
                  table_values[slot] = value;
                  entries_held++;
                  answer.status = skvt_pkg::STAT_INSERTED;
               end
            end
            skvt_pkg::CMD_REMOVE: begin
               if (hit) begin
                  // close the gap left by the removed entry
                  for (i = slot; i + 1 < entries_held; i++) begin
                     table_keys[i]   = table_keys[i+1];
                     table_values[i] = table_values[i+1];
                  end
                  entries_held--;
                  answer.status = skvt_pkg::STAT_REMOVED;
               end else begin
                  answer.status = skvt_pkg::STAT_NOT_FOUND;
               end
            end
            default: begin
               if (hit) begin
                  answer.value  = table_values[slot];
                  answer.status = skvt_pkg::STAT_FOUND;
               end else begin
                  answer.status = skvt_pkg::STAT_NOT_FOUND;
               end
            end
         endcase
      end
      answer.count = skvt_pkg::COUNT_W'(entries_held);
   endtask

   always @(posedge clock) begin : watch
      answer_type want;
      if (reset) begin
         entries_held = 0;
         expected_answers.delete();
      end else begin
         // retire the response beat before taking a new command at the same edge
         if (rsp_strobe) begin
            if (expected_answers.size() == 0) begin
               $display("%0t: unexpected beat, expected none, got status %0d value %0d count %0d",
                        $time, rsp_status, rsp_value_out, rsp_entry_count);
               errors++;
            end else begin
               want = expected_answers.pop_front();
               if (rsp_status !== want.status) begin
                  $display("%0t: status mismatch, expected %0d, actual %0d",
                           $time, want.status, rsp_status);
                  errors++;
               end
               if (rsp_value_out !== want.value) begin
                  $display("%0t: value mismatch, expected %0d, actual %0d",
                           $time, want.value, rsp_value_out);
                  errors++;
               end
               if (rsp_entry_count !== want.count) begin
                  $display("%0t: count mismatch, expected %0d, actual %0d",
                           $time, want.count, rsp_entry_count);
                  errors++;
               end
            end
         end
         if (start && !busy) begin
            predict_answer(skvt_pkg::cmd_type'(req_cmd), req_key_in, req_value_in, want);
            expected_answers.push_back(want);
         end
      end
      waiting = expected_answers.size();
   end

endmodule

@@ verif/sorted_key_value_table_tb.sv @@
`timescale 1ns / 100ps
// Testbench top for the sorted key/value table: clock, reset, command stimulus and verdict.
module sorted_key_value_table_tb;

   localparam int RANDOM_ITEMS = 550;
   localparam int POOL_SIZE    = 24;
   localparam logic [skvt_pkg::KEY_W-1:0] FILL_KEYS [16] = '{
      32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
      32'h0000_0001, 32'hFFFF_FFFE, 32'h0000_0064, 32'hFFFF_FF9C,
      32'h1234_5678, 32'hEDCB_A988, 32'h4000_0000, 32'hC000_0000,
      32'h7FFF_FFFE, 32'h8000_0001, 32'h0000_0002, 32'hFFFF_FFFD
   };

   logic                              clock = 1'b0;
   logic                              reset;
   logic                              start;
   logic                              busy;
   logic [skvt_pkg::CMD_W-1:0]        req_cmd;
   logic signed [skvt_pkg::KEY_W-1:0] req_key_in;
   logic signed [skvt_pkg::VAL_W-1:0] req_value_in;
   logic                              rsp_strobe;
   logic [skvt_pkg::STAT_W-1:0]       rsp_status;
   logic signed [skvt_pkg::VAL_W-1:0] rsp_value_out;
   logic [skvt_pkg::COUNT_W-1:0]      rsp_entry_count;
   int                                mismatches;
   int                                outstanding;

   logic [skvt_pkg::KEY_W-1:0]        key_pool [POOL_SIZE];

   always #10 clock = ~clock;

   sorted_key_value_table DUT (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_cmd         (req_cmd),
      .req_key_in      (req_key_in),
      .req_value_in    (req_value_in),
      .rsp_strobe      (rsp_strobe),
      .rsp_status      (rsp_status),
      .rsp_value_out   (rsp_value_out),
      .rsp_entry_count (rsp_entry_count)
   );

   sorted_key_value_table_checker checker_inst (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_cmd         (req_cmd),
      .req_key_in      (req_key_in),
      .req_value_in    (req_value_in),
      .rsp_strobe      (rsp_strobe),
      .rsp_status      (rsp_status),
      .rsp_value_out   (rsp_value_out),
      .rsp_entry_count (rsp_entry_count),
      .mismatch_count  (mismatches),
      .pending_count   (outstanding)
   );

   // Present one command beat and return right after the edge that accepts it.
   task automatic send_command(input skvt_pkg::cmd_type cmd,
                               input logic [skvt_pkg::KEY_W-1:0] key,
                               input logic [skvt_pkg::VAL_W-1:0] value);
      start        <= 1'b1;
      req_cmd      <= cmd;
      req_key_in   <= key;
      req_value_in <= value;
      do @(negedge clock); while (busy);
      @(posedge clock);
   endtask

   // Hold off until every predicted response has come back.
   task automatic drain_responses;
      start <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
      @(posedge clock);
   endtask

   initial begin
      #5000000;
      $display("Test completed with failures");
      $finish;
   end

   initial begin : stimulus
      int                         n;
      int                         pick;
      int                         insert_pct;
      int                         remove_pct;
      int                         lookup_pct;
      skvt_pkg::cmd_type          cmd;
      logic [skvt_pkg::KEY_W-1:0] key;
      logic [skvt_pkg::VAL_W-1:0] value;

      reset        <= 1'b1;
      start        <= 1'b0;
      req_cmd      <= skvt_pkg::CMD_LOOKUP;
      req_key_in   <= '0;
      req_value_in <= '0;
      key_pool[0] = 32'h8000_0000;
      key_pool[1] = 32'h7FFF_FFFF;
      key_pool[2] = 32'h0000_0000;
      key_pool[3] = 32'hFFFF_FFFF;
      for (n = 4; n < POOL_SIZE; n++)
         key_pool[n] = $urandom;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: empty table misses, fill out of order, full, update, edge keys, clear
      send_command(skvt_pkg::CMD_LOOKUP, 32'd5, $urandom);
      send_command(skvt_pkg::CMD_REMOVE, 32'd5, $urandom);
      for (n = 0; n < 16; n++) begin
         case (n)
            0:       value = 32'h8000_0000;
            1:       value = 32'h7FFF_FFFF;
            2:       value = 32'h0000_0000;
            3:       value = 32'hFFFF_FFFF;
            default: value = $urandom;
         endcase
         send_command(skvt_pkg::CMD_INSERT, FILL_KEYS[n], value);
      end
      send_command(skvt_pkg::CMD_INSERT, 32'd3, $urandom);
      send_command(skvt_pkg::CMD_INSERT, 32'h8000_0000, 32'h7FFF_FFFF);
      send_command(skvt_pkg::CMD_LOOKUP, 32'h7FFF_FFFF, $urandom);
      send_command(skvt_pkg::CMD_REMOVE, 32'h8000_0000, $urandom);
      send_command(skvt_pkg::CMD_LOOKUP, 32'h8000_0000, $urandom);
      send_command(skvt_pkg::CMD_CLEAR, $urandom, $urandom);
      drain_responses();

      for (n = 0; n < RANDOM_ITEMS; n++) begin
         // alternate fill-heavy and drain-heavy stretches so the table hits full and empty
         if ((n / 110) % 2 == 0) begin
            insert_pct = 55; remove_pct = 15; lookup_pct = 27;
         end else begin
            insert_pct = 25; remove_pct = 40; lookup_pct = 32;
         end
         pick = $urandom_range(99);
         if (pick < insert_pct)
            cmd = skvt_pkg::CMD_INSERT;
         else if (pick < insert_pct + remove_pct)
            cmd = skvt_pkg::CMD_REMOVE;
         else if (pick < insert_pct + remove_pct + lookup_pct)
            cmd = skvt_pkg::CMD_LOOKUP;
         else
            cmd = skvt_pkg::CMD_CLEAR;
         if ($urandom_range(99) < 85)
            key = key_pool[$urandom_range(POOL_SIZE - 1)];
         else
            key = $urandom;
         case ($urandom_range(19))
            0:       value = 32'h8000_0000;
            1:       value = 32'h7FFF_FFFF;
            2:       value = 32'h0000_0000;
            3:       value = 32'hFFFF_FFFF;
            default: value = $urandom;
         endcase
         send_command(cmd, key, value);
         if (n == 400) begin
            drain_responses();
         end else if ((n < 220 || n >= 330) && $urandom_range(99) < 25) begin
            start <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge clock);
         end
      end

      drain_responses();
      repeat (2 * skvt_pkg::CAPACITY + 8) @(posedge clock);
      if (mismatches == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
